// File: sv/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

  localparam int unsigned HOLD_FRAMES = 30;

  localparam int unsigned HoldCntW  = 6;
  localparam int unsigned SinceW    = 10;
  localparam int unsigned FrameW    = 32;
  localparam int unsigned LoadW     = 10;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned KeepW     = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [HoldCntW-1:0] HoldMax    = '1;
  localparam logic [HoldCntW-1:0] HoldTarget = HoldCntW'(HOLD_FRAMES);
  localparam logic [SinceW-1:0]   SinceMax   = '1;

  localparam logic [LoadW-1:0] BarForced = LoadW'(1000);
  localparam logic [LoadW-1:0] BarLate   = LoadW'(90);
  localparam logic [LoadW-1:0] BarMid    = LoadW'(75);
  localparam logic [LoadW-1:0] BarEarly  = LoadW'(50);

  localparam int unsigned KeepShortNum = 30 * 60;
  localparam int unsigned KeepLongNum  = 60 * 60;

  localparam logic [CfgIdxW-1:0] CfgEnabled  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInterval = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatience = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHistory  = 2'd3;

  localparam logic [1:0] HistShort = 2'd0;
  localparam logic [1:0] HistLong  = 2'd1;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef struct packed {
    logic                 enabled;
    logic [IntervalW-1:0] capture_interval;
    logic [1:0]           patience_select;
    logic [1:0]           history_limit;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic tick;
  } step_t;

  typedef struct packed {
    logic             cmd;
    logic             rewind_held;
    logic [LoadW-1:0] frame_load_percent;
    logic             suspended;
    logic             ring_ready;
  } in_item_t;

  typedef struct packed {
    logic              hold_request;
    logic              timeline_request;
    logic              capture_now;
    logic [FrameW-1:0] frame_tag;
    logic [KeepW-1:0]  keep_entries;
  } out_item_t;

  // patience window and its thirds
  function automatic logic [SinceW-1:0] patience_full(logic [1:0] sel);
    logic [SinceW-1:0] r;
    r = '0;
    unique case (sel)
      2'd0: r = SinceW'(60);
      2'd1: r = SinceW'(120);
      2'd2: r = SinceW'(240);
      2'd3: r = SinceW'(480);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SinceW-1:0] patience_two_thirds(logic [1:0] sel);
    logic [SinceW-1:0] r;
    r = '0;
    unique case (sel)
      2'd0: r = SinceW'(40);
      2'd1: r = SinceW'(80);
      2'd2: r = SinceW'(160);
      2'd3: r = SinceW'(320);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SinceW-1:0] patience_third(logic [1:0] sel);
    logic [SinceW-1:0] r;
    r = '0;
    unique case (sel)
      2'd0: r = SinceW'(20);
      2'd1: r = SinceW'(40);
      2'd2: r = SinceW'(80);
      2'd3: r = SinceW'(160);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/scp_in_if.sv
`timescale 1ns / 1ps

interface scp_in_if
  import scp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic             rewind_held;
  logic [LoadW-1:0] frame_load_percent;
  logic             suspended;
  logic             ring_ready;

  modport source (
    output valid, cmd, rewind_held, frame_load_percent, suspended, ring_ready,
    input  ready
  );

  modport sink (
    input  valid, cmd, rewind_held, frame_load_percent, suspended, ring_ready,
    output ready
  );
endinterface

// File: sv/scp_out_if.sv
`timescale 1ns / 1ps

interface scp_out_if
  import scp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              hold_request;
  logic              timeline_request;
  logic              capture_now;
  logic [FrameW-1:0] frame_tag;
  logic [KeepW-1:0]  keep_entries;

  modport source (
    output valid, hold_request, timeline_request, capture_now, frame_tag, keep_entries,
    input  ready
  );

  modport sink (
    input  valid, hold_request, timeline_request, capture_now, frame_tag, keep_entries,
    output ready
  );
endinterface

// File: sv/scp_hold.sv
`timescale 1ns / 1ps

module scp_hold
  import scp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  step_t step_i,
  input  logic  held_i,
  output logic  hold_request_o,
  output logic  timeline_request_o
);

  logic [HoldCntW-1:0] hold_cnt_q, hold_cnt_d, hold_cnt_inc;

  assign hold_cnt_inc = (hold_cnt_q == HoldMax) ? hold_cnt_q : hold_cnt_q + 1'b1;

  always_comb begin
    hold_cnt_d = hold_cnt_q;
    if (step_i.clear) begin
      hold_cnt_d = '0;
    end else if (step_i.tick) begin
      hold_cnt_d = held_i ? hold_cnt_inc : '0;
    end
  end

  assign hold_request_o = step_i.tick && held_i && (hold_cnt_inc == HoldTarget);
  assign timeline_request_o = step_i.tick && !held_i && (hold_cnt_q != '0) &&
                              (hold_cnt_q < HoldTarget);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt_q <= '0;
    end else begin
      hold_cnt_q <= hold_cnt_d;
    end
  end

endmodule

// File: sv/scp_pacer.sv
`timescale 1ns / 1ps

module scp_pacer
  import scp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  step_t             step_i,
  input  cfg_t              cfg_i,
  input  logic              ring_ready_i,
  input  logic [LoadW-1:0]  load_i,
  output logic              capture_now_o,
  output logic [FrameW-1:0] frame_tag_o,
  output logic [KeepW-1:0]  keep_entries_o
);

  localparam int unsigned TabDepth = 2 ** IntervalW;

  logic [SinceW-1:0] since_q, since_d, since_inc, waited, interval;
  logic [FrameW-1:0] frame_q, frame_d, frame_inc;
  logic [LoadW-1:0]  bar;
  logic [KeepW-1:0]  keep_short_tab [TabDepth];
  logic [KeepW-1:0]  keep_long_tab [TabDepth];
  logic              run, due, capture;

  // keep counts per interval, entry zero acts as interval one
  for (genvar g = 0; g < TabDepth; g++) begin : g_keep_tab
    localparam int unsigned Divisor = (g == 0) ? 1 : g;
    localparam logic [KeepW-1:0] KeepShort = KeepW'(KeepShortNum / Divisor);
    localparam logic [KeepW-1:0] KeepLong  = KeepW'(KeepLongNum / Divisor);
    assign keep_short_tab[g] = KeepShort;
    assign keep_long_tab[g]  = KeepLong;
  end

  assign run       = step_i.tick && ring_ready_i;
  assign interval  = (cfg_i.capture_interval == '0) ? SinceW'(1)
                                                     : SinceW'(cfg_i.capture_interval);
  assign frame_inc = frame_q + 1'b1;
  assign since_inc = (since_q == SinceMax) ? since_q : since_q + 1'b1;
  assign due       = since_inc >= interval;
  assign waited    = since_inc - interval;

  always_comb begin
    if (waited >= patience_full(cfg_i.patience_select)) begin
      bar = BarForced;
    end else if (waited >= patience_two_thirds(cfg_i.patience_select)) begin
      bar = BarLate;
    end else if (waited >= patience_third(cfg_i.patience_select)) begin
      bar = BarMid;
    end else begin
      bar = BarEarly;
    end
  end

  assign capture = run && due && (load_i <= bar);

  always_comb begin
    since_d = since_q;
    frame_d = frame_q;
    if (step_i.clear) begin
      since_d = '0;
      frame_d = '0;
    end else if (run) begin
      frame_d = frame_inc;
      since_d = capture ? '0 : since_inc;
    end
  end

  always_comb begin
    keep_entries_o = '0;
    if (capture) begin
      case (cfg_i.history_limit)
        HistShort: keep_entries_o = keep_short_tab[cfg_i.capture_interval];
        HistLong:  keep_entries_o = keep_long_tab[cfg_i.capture_interval];
        default:   keep_entries_o = '0;
      endcase
    end
  end

  assign capture_now_o = capture;
  assign frame_tag_o   = capture ? frame_inc : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q <= '0;
      frame_q <= '0;
    end else begin
      since_q <= since_d;
      frame_q <= frame_d;
    end
  end

endmodule

// File: sv/snapshot_capture_pacer_core.sv
`timescale 1ns / 1ps

// Rewind capture pacer: one item per video frame, one result item per input item, in order.
// Items pass through an input register and a result register, and a new item is taken every
// cycle while the result side keeps up, so the rate is one item per cycle, set by the
// single combinational pass between the two registers. A stalled result holds the pipeline
// without losing items. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i, by the user only while no item is in flight; the block does not enforce it.

module snapshot_capture_pacer_core
  import scp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  scp_in_if.sink              in_if,
  scp_out_if.source           out_if
);

  cfg_t      cfg_q;
  in_item_t  s1_q;
  out_item_t res_q, res_d;
  logic      s1_valid_q, res_valid_q;
  logic      in_fire, adv;
  step_t     step;

  assign adv       = s1_valid_q && (!res_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || adv;
  assign in_fire   = in_if.valid && in_if.ready;

  assign step.clear = adv && (s1_q.cmd == CmdClear);
  assign step.tick  = adv && (s1_q.cmd == CmdTick) && cfg_q.enabled && !s1_q.suspended;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled          <= 1'b0;
      cfg_q.capture_interval <= IntervalW'(120);
      cfg_q.patience_select  <= 2'd0;
      cfg_q.history_limit    <= 2'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEnabled:  cfg_q.enabled          <= cfg_data_i[0];
        CfgInterval: cfg_q.capture_interval <= cfg_data_i[IntervalW-1:0];
        CfgPatience: cfg_q.patience_select  <= cfg_data_i[1:0];
        CfgHistory:  cfg_q.history_limit    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.cmd                <= in_if.cmd;
      s1_q.rewind_held        <= in_if.rewind_held;
      s1_q.frame_load_percent <= in_if.frame_load_percent;
      s1_q.suspended          <= in_if.suspended;
      s1_q.ring_ready         <= in_if.ring_ready;
    end
  end

  scp_hold u_hold (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .held_i             (s1_q.rewind_held),
    .hold_request_o     (res_d.hold_request),
    .timeline_request_o (res_d.timeline_request)
  );

  scp_pacer u_pacer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_i          (cfg_q),
    .ring_ready_i   (s1_q.ring_ready),
    .load_i         (s1_q.frame_load_percent),
    .capture_now_o  (res_d.capture_now),
    .frame_tag_o    (res_d.frame_tag),
    .keep_entries_o (res_d.keep_entries)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid            = res_valid_q;
  assign out_if.hold_request     = res_q.hold_request;
  assign out_if.timeline_request = res_q.timeline_request;
  assign out_if.capture_now      = res_q.capture_now;
  assign out_if.frame_tag        = res_q.frame_tag;
  assign out_if.keep_entries     = res_q.keep_entries;

endmodule

// File: sim/snapshot_capture_pacer_core_tb.sv
`timescale 1ns / 1ps

module snapshot_capture_pacer_core_tb;
  import scp_pkg::*;

  class capture_pacer_tracker;
    cfg_t                regs;
    logic [HoldCntW-1:0] held_frames;
    logic [SinceW-1:0]   since_cap;
    logic [FrameW-1:0]   frame_no;
    out_item_t           pending_results[$];
    int unsigned         mismatches;
    int unsigned         results_seen;
    int unsigned         captures;
    int unsigned         holds;
    int unsigned         taps;

    function new();
      regs.enabled = 1'b0;
      regs.capture_interval = 8'd120;
      regs.patience_select = 2'd0;
      regs.history_limit = 2'd2;
      held_frames = '0;
      since_cap = '0;
      frame_no = '0;
      mismatches = 0;
      results_seen = 0;
      captures = 0;
      holds = 0;
      taps = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgEnabled:  regs.enabled = data[0];
        CfgInterval: regs.capture_interval = data;
        CfgPatience: regs.patience_select = data[1:0];
        CfgHistory:  regs.history_limit = data[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // next result for one accepted item, state advanced alongside
    function void note_frame(in_item_t it);
      out_item_t   r;
      int unsigned iv;
      int unsigned waited;
      int unsigned win;
      int unsigned bar;
      r = '0;
      if (it.cmd == CmdClear) begin
        held_frames = '0;
        since_cap = '0;
        frame_no = '0;
      end else if (regs.enabled && !it.suspended) begin
        if (it.rewind_held) begin
          if (held_frames != HoldMax) held_frames++;
          if (held_frames == HoldTarget) r.hold_request = 1'b1;
        end else begin
          if (held_frames != '0 && held_frames < HoldTarget) r.timeline_request = 1'b1;
          held_frames = '0;
        end
        if (it.ring_ready) begin
          iv = (regs.capture_interval == '0) ? 1 : int'(regs.capture_interval);
          frame_no++;
          if (since_cap != SinceMax) since_cap++;
          if (since_cap >= iv) begin
            waited = since_cap - iv;
            win = 60 << regs.patience_select;
            if (waited >= win) bar = BarForced;
            else if (waited >= win * 2 / 3) bar = BarLate;
            else if (waited >= win / 3) bar = BarMid;
            else bar = BarEarly;
            if (it.frame_load_percent <= bar) begin
              since_cap = '0;
              r.capture_now = 1'b1;
              r.frame_tag = frame_no;
              if (regs.history_limit == HistShort) r.keep_entries = KeepW'(KeepShortNum / iv);
              else if (regs.history_limit == HistLong) r.keep_entries = KeepW'(KeepLongNum / iv);
            end
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 30)
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report("result with none expected", got, '0);
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (want.capture_now) captures++;
      if (want.hold_request) holds++;
      if (want.timeline_request) taps++;
      if (got.hold_request !== want.hold_request)
        report("hold_request", got.hold_request, want.hold_request);
      if (got.timeline_request !== want.timeline_request)
        report("timeline_request", got.timeline_request, want.timeline_request);
      if (got.capture_now !== want.capture_now)
        report("capture_now", got.capture_now, want.capture_now);
      if (got.frame_tag !== want.frame_tag)
        report("frame_tag", got.frame_tag, want.frame_tag);
      if (got.keep_entries !== want.keep_entries)
        report("keep_entries", got.keep_entries, want.keep_entries);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  scp_in_if  in_if ();
  scp_out_if out_if ();

  snapshot_capture_pacer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #5 clk_i = ~clk_i;

  capture_pacer_tracker sb;
  int send_idle;
  int recv_idle;
  int items_sent;
  int settings_used;
  bit btn_on;
  int btn_left;

  function automatic in_item_t make_frame(logic cmd, logic held, int load, logic susp,
                                          logic rdy);
    in_item_t it;
    it.cmd = cmd;
    it.rewind_held = held;
    it.frame_load_percent = LoadW'(load);
    it.suspended = susp;
    it.ring_ready = rdy;
    return it;
  endfunction

  // button presses come in runs: taps, near the hold length, long holds, and any length up to 40
  function automatic in_item_t rand_frame(int busy);
    in_item_t it;
    int       load;
    if (btn_left == 0) begin
      btn_on = !btn_on;
      if (btn_on) begin
        case ($urandom_range(3))
          0: btn_left = $urandom_range(1, 5);
          1: btn_left = $urandom_range(28, 32);
          2: btn_left = $urandom_range(60, 70);
          default: btn_left = $urandom_range(1, 40);
        endcase
      end else begin
        btn_left = $urandom_range(1, 6);
      end
    end
    btn_left--;
    if ($urandom_range(99) < 8) begin
      it = make_frame($urandom_range(15) == 0, 1'($urandom_range(1)), $urandom_range(0, 1023),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      if ($urandom_range(99) < busy)
        load = ($urandom_range(9) == 0) ? $urandom_range(1001, 1023) : $urandom_range(51, 1000);
      else
        load = $urandom_range(0, 50);
      it = make_frame($urandom_range(99) < 2 ? CmdClear : CmdTick, btn_on, load,
                      $urandom_range(99) < 5, $urandom_range(99) >= 8);
    end
    return it;
  endfunction

  task automatic send_frame(input in_item_t it);
    in_if.valid <= 1'b1;
    in_if.cmd <= it.cmd;
    in_if.rewind_held <= it.rewind_held;
    in_if.frame_load_percent <= it.frame_load_percent;
    in_if.suspended <= it.suspended;
    in_if.ring_ready <= it.ring_ready;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_frame(it);
    items_sent++;
    if ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic configure(input logic en, input logic [7:0] iv, input logic [1:0] ps,
                           input logic [1:0] hl);
    while (sb.pending() != 0) @(posedge clk_i);
    write_register(CfgEnabled, CfgDataW'(en));
    write_register(CfgInterval, iv);
    write_register(CfgPatience, CfgDataW'(ps));
    write_register(CfgHistory, CfgDataW'(hl));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic en, input logic [7:0] iv, input logic [1:0] ps,
                           input logic [1:0] hl, input int busy, input int n);
    configure(en, iv, ps, hl);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        // hold off until the block has drained
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      send_frame(rand_frame(busy));
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    out_item_t got;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = {out_if.hold_request, out_if.timeline_request, out_if.capture_now,
               out_if.frame_tag, out_if.keep_entries};
        sb.check_result(got);
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    #5ms;
    $display("snapshot_capture_pacer_core_tb NOT OK");
    $finish;
  end

  initial begin
    sb = new();
    items_sent = 0;
    settings_used = 0;
    btn_on = 1'b0;
    btn_left = 0;
    send_idle = 27;
    recv_idle = 80;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.cmd <= CmdTick;
    in_if.rewind_held <= 1'b0;
    in_if.frame_load_percent <= '0;
    in_if.suspended <= 1'b0;
    in_if.ring_ready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // feature off after reset
    send_frame(make_frame(CmdTick, 1'b1, 0, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 1000, 1'b0, 1'b1));
    in_if.valid <= 1'b0;

    configure(1'b1, 8'd1, 2'd0, 2'd0);
    send_frame(make_frame(CmdClear, 1'b1, 1023, 1'b1, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 0, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 1023, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 1000, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 50, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 51, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b1, 0, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 1023, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b1, 0, 1'b1, 1'b1));
    send_frame(make_frame(CmdTick, 1'b1, 0, 1'b0, 1'b0));
    send_frame(make_frame(CmdTick, 1'b0, 0, 1'b0, 1'b0));
    send_frame(make_frame(CmdClear, 1'b0, 0, 1'b0, 1'b0));
    in_if.valid <= 1'b0;

    // interval zero acts as one
    configure(1'b1, 8'd0, 2'd3, 2'd1);
    send_frame(make_frame(CmdTick, 1'b0, 0, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 75, 1'b0, 1'b1));
    send_frame(make_frame(CmdTick, 1'b0, 512, 1'b0, 1'b1));
    in_if.valid <= 1'b0;

    configure(1'b1, 8'd255, 2'd2, 2'd3);
    send_frame(make_frame(CmdTick, 1'b0, 0, 1'b0, 1'b1));
    send_frame(make_frame(CmdClear, 1'b1, 0, 1'b0, 1'b1));
    in_if.valid <= 1'b0;

    run_phase(1'b1, 8'd1, 2'd0, 2'd0, 90, 60);
    run_phase(1'b1, 8'd30, 2'd1, 2'd1, 60, 70);

    send_idle = 80;
    recv_idle = 27;
    run_phase(1'b1, 8'd7, 2'd2, 2'd3, 85, 60);
    run_phase(1'b1, 8'd0, 2'd3, 2'd2, 97, 60);
    run_phase(1'b0, 8'd5, 2'd1, 2'd0, 50, 20);

    send_idle = 0;
    recv_idle = 0;
    run_phase(1'b1, 8'd255, 2'd0, 2'd1, 10, 110);

    // loads above the forced bar never capture, the wait runs on
    configure(1'b1, 8'd2, 2'd0, 2'd0);
    for (int i = 0; i < 100; i++)
      send_frame(make_frame(CmdTick, 1'b0, $urandom_range(1001, 1023), 1'b0, 1'b1));
    for (int i = 0; i < 3; i++)
      send_frame(make_frame(CmdTick, 1'b0, 0, 1'b0, 1'b1));
    in_if.valid <= 1'b0;

    run_phase(1'b1, 8'd3, 2'd3, 2'd0, 70, 60);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("covered %0d items over %0d register settings: %0d captures, %0d hold and %0d tap",
             items_sent, settings_used, sb.captures, sb.holds, sb.taps);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0)
      $display("snapshot_capture_pacer_core_tb OK");
    else
      $display("snapshot_capture_pacer_core_tb NOT OK");
    $finish;
  end

endmodule
